>>> design/lfpd_pkg.sv
package lfpd_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_BASE_SPEED   = 3'd0;
    localparam logic [2:0] REG_GAIN_P       = 3'd1;
    localparam logic [2:0] REG_GAIN_I       = 3'd2;
    localparam logic [2:0] REG_GAIN_D       = 3'd3;
    localparam logic [2:0] REG_LEFT_OFFSET  = 3'd4;
    localparam logic [2:0] REG_RIGHT_OFFSET = 3'd5;
    localparam logic [2:0] REG_DETECT_THR   = 3'd6;

    // field widths
    localparam int POS_W   = 13;
    localparam int READ_W  = 10;
    localparam int GAIN_W  = 18;
    localparam int ERR_W   = 13;
    localparam int SUM_W   = 11;
    localparam int DER_W   = 14;
    localparam int ACC_W   = 35;
    localparam int CORR_W  = 9;
    localparam int OFS_W   = 9;

    // control constants
    localparam logic [12:0] MAX_POS           = 13'd7000;
    localparam logic signed [13:0] CENTER_POS = 14'sd3500;
    localparam logic signed [13:0] SUM_LIMIT  = 14'sd600;
    localparam logic [7:0] CORR_LIMIT         = 8'd150;
    localparam logic [12:0] SMALL_ERR         = 13'd200;
    localparam logic [12:0] LARGE_ERR         = 13'd2000;
    localparam logic [7:0] MIN_BASE           = 8'd80;
    localparam logic [7:0] LARGE_DROP         = 8'd80;
    localparam logic [7:0] MID_DROP           = 8'd40;
    localparam logic signed [10:0] DUTY_MAX   = 11'sd255;

    // per-stage load enables of the pid datapath
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

endpackage

>>> design/line_follow_pid_drive_unit.sv
// pipeline: request accept to result valid runs through the sense, multiply,
// accumulate, correct and drive stages, one register stage each.
// throughput: one request per cycle unless m_ready stalls; pid state updates at
// accept of a tracked request, so integral and last error serve the next one.
// reset (aresetn low, synchronous): pipeline emptied, pid state zeroed,
// configuration registers back to their defaults.
module line_follow_pid_drive_unit #(
    parameter int SENSOR_COUNT = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [17:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [12:0] s_line_position,
    input  logic [9:0]  s_sensor_0,
    input  logic [9:0]  s_sensor_1,
    input  logic [9:0]  s_sensor_2,
    input  logic [9:0]  s_sensor_3,
    input  logic [9:0]  s_sensor_4,
    input  logic [9:0]  s_sensor_5,
    input  logic [9:0]  s_sensor_6,
    input  logic [9:0]  s_sensor_7,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_left_forward,
    output logic [7:0]  m_left_duty,
    output logic        m_right_forward,
    output logic [7:0]  m_right_duty,
    output logic        m_line_lost,
    output logic signed [8:0] m_correction
);

    localparam int CNT_W = $clog2(SENSOR_COUNT + 1);

    // configuration registers
    logic [7:0]                        base_speed_reg;
    logic [lfpd_pkg::GAIN_W-1:0]       gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [lfpd_pkg::OFS_W-1:0] left_offset_reg, right_offset_reg;
    logic [lfpd_pkg::READ_W-1:0]       detect_thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_speed_reg   <= 8'd200;
            gain_p_reg       <= 18'd5243;
            gain_i_reg       <= 18'd7;
            gain_d_reg       <= 18'd3277;
            left_offset_reg  <= 9'sd0;
            right_offset_reg <= -9'sd5;
            detect_thr_reg   <= 10'd500;
        end else if (cfg_we) begin
            case (cfg_addr)
                lfpd_pkg::REG_BASE_SPEED:   base_speed_reg   <= cfg_wdata[7:0];
                lfpd_pkg::REG_GAIN_P:       gain_p_reg       <= cfg_wdata;
                lfpd_pkg::REG_GAIN_I:       gain_i_reg       <= cfg_wdata;
                lfpd_pkg::REG_GAIN_D:       gain_d_reg       <= cfg_wdata;
                lfpd_pkg::REG_LEFT_OFFSET:  left_offset_reg  <= $signed(cfg_wdata[8:0]);
                lfpd_pkg::REG_RIGHT_OFFSET: right_offset_reg <= $signed(cfg_wdata[8:0]);
                lfpd_pkg::REG_DETECT_THR:   detect_thr_reg   <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control: a stage loads when empty or draining
    logic [5:1] valid_reg;
    logic [5:1] adv;
    logic       accept;

    assign adv[5]  = ~valid_reg[5] | m_ready;
    assign adv[4]  = ~valid_reg[4] | adv[5];
    assign adv[3]  = ~valid_reg[3] | adv[4];
    assign adv[2]  = ~valid_reg[2] | adv[3];
    assign adv[1]  = ~valid_reg[1] | adv[2];
    assign s_ready = adv[1];
    assign accept  = s_valid & adv[1];
    assign m_valid = valid_reg[5];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[1]) valid_reg[1] <= s_valid;
            if (adv[2]) valid_reg[2] <= valid_reg[1];
            if (adv[3]) valid_reg[3] <= valid_reg[2];
            if (adv[4]) valid_reg[4] <= valid_reg[3];
            if (adv[5]) valid_reg[5] <= valid_reg[4];
        end
    end

    // sensor lanes
    logic [lfpd_pkg::READ_W-1:0] sensor_arr [8];
    logic [SENSOR_COUNT-1:0]     hit;

    assign sensor_arr[0] = s_sensor_0;
    assign sensor_arr[1] = s_sensor_1;
    assign sensor_arr[2] = s_sensor_2;
    assign sensor_arr[3] = s_sensor_3;
    assign sensor_arr[4] = s_sensor_4;
    assign sensor_arr[5] = s_sensor_5;
    assign sensor_arr[6] = s_sensor_6;
    assign sensor_arr[7] = s_sensor_7;

    for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
        lfpd_lane u_lane (
            .reading   (sensor_arr[g]),
            .threshold (detect_thr_reg),
            .hit       (hit[g])
        );
    end

    // merge: count lanes that see the line
    logic [CNT_W-1:0] active;

    always_comb begin
        active = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            active = active + CNT_W'(hit[i]);
        end
    end

    // stage 1: error, integral, derivative
    logic signed [lfpd_pkg::ERR_W-1:0] last_error_reg;
    logic signed [lfpd_pkg::SUM_W-1:0] error_sum_reg;
    logic [12:0]  pos_sat;
    logic signed [13:0] err_wide, sum_wide;
    logic signed [lfpd_pkg::ERR_W-1:0] err_next;
    logic signed [lfpd_pkg::SUM_W-1:0] sum_next;
    logic signed [lfpd_pkg::DER_W-1:0] deriv_next;
    logic         lost_next;

    always_comb begin
        pos_sat  = (s_line_position > lfpd_pkg::MAX_POS) ? lfpd_pkg::MAX_POS
                                                         : s_line_position;
        err_wide = $signed({1'b0, pos_sat}) - lfpd_pkg::CENTER_POS;
        err_next = err_wide[12:0];
        sum_wide = {{3{error_sum_reg[10]}}, error_sum_reg} + {err_next[12], err_next};
        if (sum_wide > lfpd_pkg::SUM_LIMIT) begin
            sum_next = 11'(lfpd_pkg::SUM_LIMIT);
        end else if (sum_wide < -lfpd_pkg::SUM_LIMIT) begin
            sum_next = 11'(-lfpd_pkg::SUM_LIMIT);
        end else begin
            sum_next = sum_wide[10:0];
        end
        deriv_next = {err_next[12], err_next} - {last_error_reg[12], last_error_reg};
        lost_next  = (active < CNT_W'(2));
    end

    // pid state moves only for tracked requests
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_error_reg <= '0;
            error_sum_reg  <= '0;
        end else if (accept && !lost_next) begin
            last_error_reg <= err_next;
            error_sum_reg  <= sum_next;
        end
    end

    logic signed [lfpd_pkg::ERR_W-1:0] err1_reg;
    logic signed [lfpd_pkg::SUM_W-1:0] sum1_reg;
    logic signed [lfpd_pkg::DER_W-1:0] der1_reg;
    logic lost1_reg, lpos1_reg;

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            err1_reg  <= err_next;
            sum1_reg  <= sum_next;
            der1_reg  <= deriv_next;
            lost1_reg <= lost_next;
            lpos1_reg <= (last_error_reg > 13'sd0);
        end
    end

    // stages 2 to 4
    lfpd_pkg::stage_en_t pid_en;
    logic signed [lfpd_pkg::CORR_W-1:0] corr4;
    logic [7:0] vb4;
    logic lost4, lpos4;

    assign pid_en.s2 = adv[2];
    assign pid_en.s3 = adv[3];
    assign pid_en.s4 = adv[4];

    lfpd_pid u_pid (
        .aclk         (aclk),
        .en           (pid_en),
        .err          (err1_reg),
        .esum         (sum1_reg),
        .deriv        (der1_reg),
        .lost_in      (lost1_reg),
        .last_pos_in  (lpos1_reg),
        .gain_p       (gain_p_reg),
        .gain_i       (gain_i_reg),
        .gain_d       (gain_d_reg),
        .base_speed   (base_speed_reg),
        .corr         (corr4),
        .vb           (vb4),
        .lost_out     (lost4),
        .last_pos_out (lpos4)
    );

    // stage 5: wheel drive and result register
    lfpd_drive u_drive (
        .aclk          (aclk),
        .en            (adv[5]),
        .lost          (lost4),
        .last_pos      (lpos4),
        .corr          (corr4),
        .vb            (vb4),
        .base_speed    (base_speed_reg),
        .left_offset   (left_offset_reg),
        .right_offset  (right_offset_reg),
        .left_forward  (m_left_forward),
        .left_duty     (m_left_duty),
        .right_forward (m_right_forward),
        .right_duty    (m_right_duty),
        .line_lost     (m_line_lost),
        .correction    (m_correction)
    );

endmodule

>>> design/lfpd_lane.sv
module lfpd_lane (
    input  logic [lfpd_pkg::READ_W-1:0] reading,
    input  logic [lfpd_pkg::READ_W-1:0] threshold,
    output logic                        hit
);

    // a sensor sees the line when strictly above threshold
    assign hit = (reading > threshold);

endmodule

>>> design/lfpd_pid.sv
module lfpd_pid (
    input  logic                                aclk,
    input  lfpd_pkg::stage_en_t                 en,
    input  logic signed [lfpd_pkg::ERR_W-1:0]   err,
    input  logic signed [lfpd_pkg::SUM_W-1:0]   esum,
    input  logic signed [lfpd_pkg::DER_W-1:0]   deriv,
    input  logic                                lost_in,
    input  logic                                last_pos_in,
    input  logic [lfpd_pkg::GAIN_W-1:0]         gain_p,
    input  logic [lfpd_pkg::GAIN_W-1:0]         gain_i,
    input  logic [lfpd_pkg::GAIN_W-1:0]         gain_d,
    input  logic [7:0]                          base_speed,
    output logic signed [lfpd_pkg::CORR_W-1:0]  corr,
    output logic [7:0]                          vb,
    output logic                                lost_out,
    output logic                                last_pos_out
);

    logic signed [31:0] prod_p_reg, prod_p_next;
    logic signed [29:0] prod_i_reg, prod_i_next;
    logic signed [32:0] prod_d_reg, prod_d_next;
    logic signed [lfpd_pkg::ERR_W-1:0] err2_reg, err3_reg;
    logic lost2_reg, lost3_reg, lost4_reg;
    logic lpos2_reg, lpos3_reg, lpos4_reg;
    logic signed [lfpd_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic signed [lfpd_pkg::ACC_W-1:0] mag;
    logic [18:0] mag_int;
    logic [7:0]  corr_mag;
    logic signed [lfpd_pkg::CORR_W-1:0] corr_reg, corr_next;
    logic [7:0] vb_reg, vb_next;
    logic [12:0] aerr;

    function automatic logic signed [lfpd_pkg::ACC_W-1:0] ACC_W_EXT(logic signed [31:0] v);
        return {{(lfpd_pkg::ACC_W-32){v[31]}}, v};
    endfunction

    function automatic logic signed [lfpd_pkg::ACC_W-1:0] ACC_I_EXT(logic signed [29:0] v);
        return {{(lfpd_pkg::ACC_W-30){v[29]}}, v};
    endfunction

    function automatic logic signed [lfpd_pkg::ACC_W-1:0] ACC_D_EXT(logic signed [32:0] v);
        return {{(lfpd_pkg::ACC_W-33){v[32]}}, v};
    endfunction

    // stage 2: gain products
    assign prod_p_next = $signed({1'b0, gain_p}) * err;
    assign prod_i_next = $signed({1'b0, gain_i}) * esum;
    assign prod_d_next = $signed({1'b0, gain_d}) * deriv;

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
            err2_reg   <= err;
            lost2_reg  <= lost_in;
            lpos2_reg  <= last_pos_in;
        end
    end

    // stage 3: q16 accumulation
    assign acc_next = ACC_W_EXT(prod_p_reg) + ACC_I_EXT(prod_i_reg) + ACC_D_EXT(prod_d_reg);

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            acc_reg   <= acc_next;
            err3_reg  <= err2_reg;
            lost3_reg <= lost2_reg;
            lpos3_reg <= lpos2_reg;
        end
    end

    // stage 4: truncate toward zero, clamp, pick base speed
    always_comb begin
        mag      = acc_reg[lfpd_pkg::ACC_W-1] ? -acc_reg : acc_reg;
        mag_int  = mag[34:16];
        corr_mag = (mag_int > {11'd0, lfpd_pkg::CORR_LIMIT}) ? lfpd_pkg::CORR_LIMIT
                                                             : mag_int[7:0];
        corr_next = acc_reg[lfpd_pkg::ACC_W-1] ? -$signed({1'b0, corr_mag})
                                               : $signed({1'b0, corr_mag});
        aerr = err3_reg[lfpd_pkg::ERR_W-1] ? 13'(-err3_reg) : 13'(err3_reg);
        if (aerr < lfpd_pkg::SMALL_ERR) begin
            vb_next = base_speed;
        end else if (aerr > lfpd_pkg::LARGE_ERR) begin
            vb_next = (base_speed < lfpd_pkg::MIN_BASE + lfpd_pkg::LARGE_DROP)
                      ? lfpd_pkg::MIN_BASE : base_speed - lfpd_pkg::LARGE_DROP;
        end else begin
            vb_next = (base_speed < lfpd_pkg::MIN_BASE + lfpd_pkg::MID_DROP)
                      ? lfpd_pkg::MIN_BASE : base_speed - lfpd_pkg::MID_DROP;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            corr_reg  <= corr_next;
            vb_reg    <= vb_next;
            lost4_reg <= lost3_reg;
            lpos4_reg <= lpos3_reg;
        end
    end

    assign corr         = corr_reg;
    assign vb           = vb_reg;
    assign lost_out     = lost4_reg;
    assign last_pos_out = lpos4_reg;

endmodule

>>> design/lfpd_drive.sv
module lfpd_drive (
    input  logic                                aclk,
    input  logic                                en,
    input  logic                                lost,
    input  logic                                last_pos,
    input  logic signed [lfpd_pkg::CORR_W-1:0]  corr,
    input  logic [7:0]                          vb,
    input  logic [7:0]                          base_speed,
    input  logic signed [lfpd_pkg::OFS_W-1:0]   left_offset,
    input  logic signed [lfpd_pkg::OFS_W-1:0]   right_offset,
    output logic                                left_forward,
    output logic [7:0]                          left_duty,
    output logic                                right_forward,
    output logic [7:0]                          right_duty,
    output logic                                line_lost,
    output logic signed [lfpd_pkg::CORR_W-1:0]  correction
);

    logic signed [10:0] half, vb_s, corr_s, l_raw, r_raw, l_cmd, r_cmd;
    logic signed [10:0] l_trim, r_trim, l_fin, r_fin;
    logic               lf_reg, rf_reg, lost_reg;
    logic [7:0]         ld_reg, rd_reg;
    logic signed [lfpd_pkg::CORR_W-1:0] corr_reg;

    function automatic logic signed [10:0] clamp11(logic signed [10:0] v,
                                                   logic signed [10:0] lo,
                                                   logic signed [10:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // wheel commands before trim
    always_comb begin
        half   = $signed({4'd0, base_speed[7:1]});
        vb_s   = $signed({3'd0, vb});
        corr_s = {{2{corr[lfpd_pkg::CORR_W-1]}}, corr};
        l_raw  = clamp11(vb_s - corr_s, 11'sd0, lfpd_pkg::DUTY_MAX);
        r_raw  = clamp11(vb_s + corr_s, 11'sd0, lfpd_pkg::DUTY_MAX);
        if (lost) begin
            // spin in place toward the side of the last error
            l_cmd = last_pos ? half : -half;
            r_cmd = last_pos ? -half : half;
        end else begin
            l_cmd = l_raw;
            r_cmd = r_raw;
        end
        l_trim = l_cmd + {{2{left_offset[lfpd_pkg::OFS_W-1]}}, left_offset};
        r_trim = r_cmd + {{2{right_offset[lfpd_pkg::OFS_W-1]}}, right_offset};
        l_fin  = clamp11(l_trim, -lfpd_pkg::DUTY_MAX, lfpd_pkg::DUTY_MAX);
        r_fin  = clamp11(r_trim, -lfpd_pkg::DUTY_MAX, lfpd_pkg::DUTY_MAX);
    end

    // output register
    always_ff @(posedge aclk) begin
        if (en) begin
            lf_reg   <= ~l_fin[10];
            ld_reg   <= l_fin[10] ? 8'(-l_fin) : l_fin[7:0];
            rf_reg   <= ~r_fin[10];
            rd_reg   <= r_fin[10] ? 8'(-r_fin) : r_fin[7:0];
            lost_reg <= lost;
            corr_reg <= lost ? '0 : corr;
        end
    end

    assign left_forward  = lf_reg;
    assign left_duty     = ld_reg;
    assign right_forward = rf_reg;
    assign right_duty    = rd_reg;
    assign line_lost     = lost_reg;
    assign correction    = corr_reg;

endmodule
